@@ src/assert_macros.svh @@
// Assertion macros used by the top level of the maximum-xor trie block.
// Concurrent checks are active in simulation and compile to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define BTMX_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that also holds during reset.
`define BTMX_ASSERT_NR(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BTMX_ASSERT(name, clk, rst_n, prop, msg)
`define BTMX_ASSERT_NR(name, clk, prop, msg)
`endif

`endif

@@ src/btmx_pkg.sv @@
// Shared types and constants for the maximum-xor trie block.
// No dependencies; imported by btmx_level and the top level of the block.
`timescale 1ns / 1ps
`default_nettype none

package btmx_pkg;

  // Fixed widths of the request and result ports
  localparam int unsigned KEY_IN_BITS = 32;
  localparam int unsigned ANSWER_BITS = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_HELD = 2'd2
  } status_e;

  // What the level unit does with the current trie node
  typedef enum logic [2:0] {
    WALK_NONE       = 3'd0,
    WALK_CHECK_INS  = 3'd1,
    WALK_CHECK_REM  = 3'd2,
    WALK_COMMIT_INS = 3'd3,
    WALK_COMMIT_REM = 3'd4,
    WALK_QUERY      = 3'd5
  } walk_e;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_COMMIT = 5'b00100,
    S_QUERY  = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  // Per-level decisions from the level unit to the sequencer
  typedef struct packed {
    logic fail;     // check walk rejects the request
    logic missing;  // insert check walk hit a missing edge
    logic alloc;    // commit walk takes a new node here
    logic stop;     // query walk has no edge to follow
    logic best;     // query: bit of the best member at this level
  } lvl_ctl_t;

endpackage

`default_nettype wire

@@ src/btmx_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the trie node rows.
`timescale 1ns / 1ps
`default_nettype none

module btmx_ram #(
  parameter int unsigned WIDTH = 72,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one row, read one row
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/btmx_level.sv @@
// Shared level unit: examines one trie node row for one key bit and decides
// the next node, the updated row and the walk control. Depends on btmx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btmx_level #(
  parameter int unsigned NODE_BITS  = 16,
  parameter int unsigned COUNT_BITS = 20
) (
  input  wire btmx_pkg::walk_e       mode_i,
  input  wire logic                  bit_i,
  input  wire logic                  fresh_i,
  input  wire logic [NODE_BITS-1:0]  free_i,
  input  wire logic [NODE_BITS-1:0]  child0_i,
  input  wire logic [NODE_BITS-1:0]  child1_i,
  input  wire logic [COUNT_BITS-1:0] cnt0_i,
  input  wire logic [COUNT_BITS-1:0] cnt1_i,
  output logic      [NODE_BITS-1:0]  next_o,
  output logic      [NODE_BITS-1:0]  child0_o,
  output logic      [NODE_BITS-1:0]  child1_o,
  output logic      [COUNT_BITS-1:0] cnt0_o,
  output logic      [COUNT_BITS-1:0] cnt1_o,
  output btmx_pkg::lvl_ctl_t         ctl_o
);

  import btmx_pkg::*;

  logic [NODE_BITS-1:0]  c0, c1, cb, cw, new_child;
  logic [COUNT_BITS-1:0] n0, n1, nb, nw, cnt_new;
  logic                  has_b, live_b, has_w, live_w, take_w;
  lvl_ctl_t              ctl;

  always_comb begin
    // A freshly allocated node reads as all zero
    c0 = fresh_i ? '0 : child0_i;
    c1 = fresh_i ? '0 : child1_i;
    n0 = fresh_i ? '0 : cnt0_i;
    n1 = fresh_i ? '0 : cnt1_i;

    // Pick the edge of the key bit and the opposite edge
    cb = bit_i ? c1 : c0;
    cw = bit_i ? c0 : c1;
    nb = bit_i ? n1 : n0;
    nw = bit_i ? n0 : n1;

    has_b  = (cb != '0);
    live_b = (nb != '0);
    has_w  = (cw != '0);
    live_w = (nw != '0);
    take_w = has_w && live_w;

    // One counter adjust, shared by insert and remove
    cnt_new = (mode_i == WALK_COMMIT_REM) ? nb - COUNT_BITS'(1) : nb + COUNT_BITS'(1);

    ctl = '0;
    case (mode_i)
      WALK_CHECK_INS: begin
        ctl.fail    = &nb;
        ctl.missing = !(&nb) && !has_b;
      end
      WALK_CHECK_REM: begin
        ctl.fail = !has_b || !live_b;
      end
      WALK_COMMIT_INS: begin
        ctl.alloc = !has_b;
      end
      WALK_QUERY: begin
        ctl.stop = !take_w && !live_b;
        ctl.best = take_w ? !bit_i : bit_i;
      end
      default: begin
        ctl = '0;
      end
    endcase

    // Build the updated row and the next node
    new_child = ctl.alloc ? free_i : cb;
    next_o    = ((mode_i == WALK_QUERY) && take_w) ? cw : new_child;
    child0_o  = bit_i ? c0 : new_child;
    child1_o  = bit_i ? new_child : c1;
    cnt0_o    = bit_i ? n0 : cnt_new;
    cnt1_o    = bit_i ? cnt_new : n1;
    ctl_o     = ctl;
  end

endmodule

`default_nettype wire

@@ src/binary_trie_max_xor_multiset.sv @@
// Top level of the maximum-xor trie block: request sequencer, root node
// registers and node RAM. Depends on btmx_pkg, btmx_level, btmx_ram, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Keeps a multiset of keys in a binary trie and answers maximum-xor queries.
// Request channel: op_i and key_i are taken at a rising edge with start high
// and busy low. busy stays high until the result has been presented.
// Result channel: done_o is high for exactly one cycle with answer_o and
// status_o; the receiver cannot stall, so the result must be taken then.
// Each request walks the trie one level per cycle, from the top key bit down,
// using one node-RAM read (registered, address driven from the row just read)
// and at most one row write per level; the root node lives in flip-flops.
// Steps from accept to done_o: a query runs one query walk, which ends early
// if it runs out of edges; insert and remove run a check walk, then a commit
// walk; a rejected request ends after its check walk; an unknown op goes
// straight to the result.
// The next request can be accepted in the cycle done_o is high.
// Reset clears the root node and sets the free counter to one; no clearing
// pass is needed, as a newly allocated node reads as zero until written.
module binary_trie_max_xor_multiset #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned NODE_COUNT = 65536,
  parameter int unsigned COUNT_BITS = 20
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [1:0]                            op_i,
  input  wire logic [btmx_pkg::KEY_IN_BITS-1:0]      key_i,
  output logic                                       done_o,
  output logic      [btmx_pkg::ANSWER_BITS-1:0]      answer_o,
  output logic      [1:0]                            status_o
);

  import btmx_pkg::*;

  localparam int unsigned NODE_BITS = $clog2(NODE_COUNT);
  localparam int unsigned NF_BITS   = NODE_BITS + 1;
  localparam int unsigned SUM_BITS  = NODE_BITS + 2;
  localparam int unsigned LVL_BITS  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int unsigned ROW_BITS  = 2 * NODE_BITS + 2 * COUNT_BITS;
  localparam logic [LVL_BITS-1:0] LVL_TOP = LVL_BITS'(KEY_BITS - 1);

  state_e                 state_q, state_d;
  op_e                    op_q;
  logic [KEY_BITS-1:0]    key_q, best_q, xor_key;
  logic [LVL_BITS-1:0]    level_q, level_d;
  logic [NODE_BITS-1:0]   node_q, node_d;
  logic                   fresh_q, fresh_d;
  logic [NF_BITS-1:0]     next_free_q, next_free_d;
  status_e                status_q, status_d;
  logic                   done_q, done_d;
  logic [ANSWER_BITS-1:0] out_answer_q;
  status_e                out_status_q;
  logic [SUM_BITS-1:0]    need_sum;
  logic                   accept, best_we, root_we, ram_we;

  // Root node row
  logic [NODE_BITS-1:0]  root_c0_q, root_c1_q;
  logic [COUNT_BITS-1:0] root_n0_q, root_n1_q;

  // Row seen by the level unit and the row it writes back
  logic [ROW_BITS-1:0]   ram_rdata, ram_wdata;
  logic [NODE_BITS-1:0]  row_c0, row_c1, wr_c0, wr_c1, lvl_next;
  logic [COUNT_BITS-1:0] row_n0, row_n1, wr_n0, wr_n1;
  walk_e                 mode;
  lvl_ctl_t              ctl;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // Select the row of the current node: root from flops, others from RAM
  always_comb begin
    if (node_q == '0) begin
      row_c0 = root_c0_q;
      row_c1 = root_c1_q;
      row_n0 = root_n0_q;
      row_n1 = root_n1_q;
    end else begin
      {row_c1, row_c0, row_n1, row_n0} = ram_rdata;
    end
  end

  // Map the sequencer state to a level-unit operation
  always_comb begin
    case (state_q)
      S_CHECK:  mode = (op_q == OP_INSERT) ? WALK_CHECK_INS : WALK_CHECK_REM;
      S_COMMIT: mode = (op_q == OP_INSERT) ? WALK_COMMIT_INS : WALK_COMMIT_REM;
      S_QUERY:  mode = WALK_QUERY;
      default:  mode = WALK_NONE;
    endcase
  end

  btmx_level #(
    .NODE_BITS  (NODE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_level (
    .mode_i   (mode),
    .bit_i    (key_q[level_q]),
    .fresh_i  (fresh_q),
    .free_i   (next_free_q[NODE_BITS-1:0]),
    .child0_i (row_c0),
    .child1_i (row_c1),
    .cnt0_i   (row_n0),
    .cnt1_i   (row_n1),
    .next_o   (lvl_next),
    .child0_o (wr_c0),
    .child1_o (wr_c1),
    .cnt0_o   (wr_n0),
    .cnt1_o   (wr_n1),
    .ctl_o    (ctl)
  );

  assign ram_wdata = {wr_c1, wr_c0, wr_n1, wr_n0};

  // Free counter once the insert has taken the nodes it still needs after a missing edge
  assign need_sum = SUM_BITS'(next_free_q) + SUM_BITS'(level_q) + SUM_BITS'(1);

  // Sequence the walks
  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    node_d      = '0;
    fresh_d     = 1'b0;
    next_free_d = next_free_q;
    status_d    = status_q;
    done_d      = 1'b0;
    root_we     = 1'b0;
    ram_we      = 1'b0;
    best_we     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          level_d  = LVL_TOP;
          status_d = ST_OK;
          case (op_e'(op_i))
            OP_INSERT: state_d = S_CHECK;
            OP_REMOVE: state_d = S_CHECK;
            OP_QUERY:  state_d = S_QUERY;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_CHECK: begin
        if (ctl.fail) begin
          status_d = (op_q == OP_INSERT) ? ST_FULL : ST_NOT_HELD;
          state_d  = S_DONE;
        end else if (ctl.missing) begin
          if (need_sum > SUM_BITS'(NODE_COUNT)) begin
            status_d = ST_FULL;
            state_d  = S_DONE;
          end else begin
            state_d = S_COMMIT;
            level_d = LVL_TOP;
          end
        end else if (level_q == '0) begin
          state_d = S_COMMIT;
          level_d = LVL_TOP;
        end else begin
          level_d = level_q - LVL_BITS'(1);
          node_d  = lvl_next;
        end
      end
      S_COMMIT: begin
        root_we = (node_q == '0);
        ram_we  = (node_q != '0);
        if (ctl.alloc) begin
          next_free_d = next_free_q + NF_BITS'(1);
        end
        if (level_q == '0) begin
          state_d = S_DONE;
        end else begin
          level_d = level_q - LVL_BITS'(1);
          node_d  = lvl_next;
          fresh_d = ctl.alloc;
        end
      end
      S_QUERY: begin
        best_we = !ctl.stop;
        if (ctl.stop || (level_q == '0)) begin
          state_d = S_DONE;
        end else begin
          level_d = level_q - LVL_BITS'(1);
          node_d  = lvl_next;
        end
      end
      S_DONE: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state and the root node
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      level_q     <= '0;
      node_q      <= '0;
      fresh_q     <= 1'b0;
      next_free_q <= NF_BITS'(1);
      status_q    <= ST_OK;
      done_q      <= 1'b0;
      root_c0_q   <= '0;
      root_c1_q   <= '0;
      root_n0_q   <= '0;
      root_n1_q   <= '0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      node_q      <= node_d;
      fresh_q     <= fresh_d;
      next_free_q <= next_free_d;
      status_q    <= status_d;
      done_q      <= done_d;
      if (root_we) begin
        root_c0_q <= wr_c0;
        root_c1_q <= wr_c1;
        root_n0_q <= wr_n0;
        root_n1_q <= wr_n1;
      end
    end
  end

  assign xor_key = key_q ^ best_q;

  // Capture the request, build the best member, register the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(op_i);
      key_q  <= KEY_BITS'(key_i);
      best_q <= '0;
    end else if (best_we) begin
      best_q[level_q] <= ctl.best;
    end
    if (state_q == S_DONE) begin
      out_status_q <= status_q;
      if (op_q == OP_QUERY) begin
        out_answer_q <= ANSWER_BITS'((xor_key > key_q) ? xor_key : key_q);
      end else begin
        out_answer_q <= '0;
      end
    end
  end

  btmx_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (node_q),
    .wdata_i (ram_wdata),
    .raddr_i (node_d),
    .rdata_o (ram_rdata)
  );

  assign done_o   = done_q;
  assign answer_o = out_answer_q;
  assign status_o = out_status_q;

  // A result strobe is never held high
  `BTMX_ASSERT(a_done_single, clk_i, rst_ni, done_q |=> !done_q, "result strobe held")
  // An accepted request makes the block busy
  `BTMX_ASSERT(a_accept_busy, clk_i, rst_ni, accept |=> busy, "request accepted but not busy")
  // A rejected check walk leaves the free counter alone
  `BTMX_ASSERT(a_reject_keeps_free, clk_i, rst_ni,
    (state_q == S_CHECK && ctl.fail) |=> $stable(next_free_q), "free counter moved on reject")
  // Fresh-node rows are only ever used while committing an insert
  `BTMX_ASSERT(a_fresh_in_commit, clk_i, rst_ni,
    fresh_q |-> (state_q == S_COMMIT && op_q == OP_INSERT), "fresh node outside insert")
  // Rejected results carry a zero answer
  `BTMX_ASSERT(a_reject_zero, clk_i, rst_ni,
    (done_q && out_status_q != ST_OK) |-> (out_answer_q == '0), "rejected result has answer")

endmodule

`default_nettype wire
